// ===== hdl/clock_sync_peer_engine_assert.svh =====
// Assertion macros used by the checker file cspe_checker.sv.
// No dependencies.
`ifndef CLOCK_SYNC_PEER_ENGINE_ASSERT_SVH
`define CLOCK_SYNC_PEER_ENGINE_ASSERT_SVH
// implication checked every clock outside reset
`define CSPE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define CSPE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== hdl/cspe_pkg.sv =====
// Package for the clock sync peer engine: payload structs, codes, constants.
// No dependencies.
package cspe_pkg;
  localparam int unsigned CfgW = 20;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned OffW = 50;

  typedef enum logic [3:0] {
    REQ_TICK = 4'd0, REQ_HELLO = 4'd1, REQ_CONNECT = 4'd2, REQ_ACK_CONNECT = 4'd3,
    REQ_SYNC_BEGIN = 4'd4, REQ_DELAY_REQ = 4'd5, REQ_DELAY_RESP = 4'd6,
    REQ_LEADER = 4'd7, REQ_GET_TIME = 4'd8
  } req_code_t;

  typedef enum logic [2:0] {
    SEND_NONE = 3'd0, SEND_ERROR = 3'd1, SEND_HELLO_REPLY = 3'd2, SEND_ACK_CONNECT = 3'd3,
    SEND_SYNC_BEGIN = 3'd4, SEND_DELAY_REQ = 3'd5, SEND_DELAY_RESP = 3'd6, SEND_TIME = 3'd7
  } send_code_t;

  localparam logic CFG_SYNC_TIMEOUT = 1'b0;
  localparam logic CFG_ANNOUNCE_PERIOD = 1'b1;
  localparam logic [CfgW-1:0] SyncTimeoutReset = 20'd21000;
  localparam logic [CfgW-1:0] AnnouncePeriodReset = 20'd6000;
  localparam logic [7:0] LevelUnsynced = 8'd255;
  localparam logic [7:0] LevelNoAnnounce = 8'd254;

  typedef struct packed {
    logic [3:0]         req_type;
    logic [31:0]        sender_addr;
    logic [15:0]        src_port;
    logic [7:0]         msg_level;
    logic signed [47:0] msg_timestamp;
    logic [46:0]        now_ms;
  } req_t;

  typedef struct packed {
    logic [2:0]         send_kind;
    logic [31:0]        dest_addr;
    logic [15:0]        dest_port;
    logic [7:0]         out_level;
    logic signed [47:0] out_timestamp;
    logic               last_of_run;
  } send_t;

  // 64-bit signed saturation to 48 bits
  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_7FFF_FFFF_FFFF;
    lo = -hi - 64'sd1;
    if (v > hi) sat48 = hi[47:0];
    else if (v < lo) sat48 = lo[47:0];
    else sat48 = v[47:0];
  endfunction

  function automatic logic signed [OffW-1:0] sat50(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0001_FFFF_FFFF_FFFF;
    lo = -hi - 64'sd1;
    if (v > hi) sat50 = hi[OffW-1:0];
    else if (v < lo) sat50 = lo[OffW-1:0];
    else sat50 = v[OffW-1:0];
  endfunction
endpackage

// ===== hdl/cspe_front.sv =====
// Front end: a two-entry queue of transactions.
// Depends on cspe_pkg.
module cspe_front
  import cspe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_item,
  output logic q_valid,
  input  logic q_pop,
  output req_t q_item
);
  req_t   buf_q [2];
  logic   wr_ptr, rd_ptr;
  logic [1:0] count;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = buf_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (in_valid && in_ready) begin
        buf_q[wr_ptr] <= in_item;
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop && q_valid) rd_ptr <= ~rd_ptr;
      count <= count + 2'((in_valid && in_ready) ? 1 : 0) - 2'((q_pop && q_valid) ? 1 : 0);
    end
  end
endmodule

// ===== hdl/cspe_back.sv =====
// Back end: sequencer that runs one transaction over several cycles,
// walks the peer table and emits results through an output register.
// Depends on cspe_pkg.
module cspe_back
  import cspe_pkg::*;
#(
  parameter int unsigned PEER_SLOTS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_idx,
  input  logic [CfgW-1:0] cfg_data,
  input  logic            q_valid,
  output logic            q_pop,
  input  req_t            q_item,
  output logic            out_valid,
  input  logic            out_ready,
  output send_t           out_item
);
  localparam int unsigned IdxW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(PEER_SLOTS + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_TMO   = 6'b000010,
    ST_DISP  = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_ACT   = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t state;
  req_t   cur;
  logic [47:0] peer_table [PEER_SLOTS];
  logic [CntW-1:0] peer_fill;
  logic [7:0]  my_level;
  logic [47:0] synced_peer, candidate_peer;
  logic        synchronizing;
  logic signed [OffW-1:0] current_offset, pending_offset;
  logic [46:0] last_sync_ms, last_announce_ms;
  logic [CfgW-1:0] sync_timeout_ms, announce_period_ms;

  logic [CntW-1:0] scan_i;
  logic [4:0]      emitted;
  logic            found;
  logic [47:0]     sender;
  logic            tmo_hit, ann_hit;
  logic signed [63:0] synced_time;
  logic            slot_free;

  assign sender = {cur.sender_addr, cur.src_port};
  assign slot_free = (peer_fill < CntW'(PEER_SLOTS));
  assign synced_time = $signed({17'd0, cur.now_ms}) - 64'(current_offset);

  // elapsed time clamps to 0 when the clock runs backwards
  always_comb begin
    tmo_hit = 1'b0;
    if (cur.now_ms >= last_sync_ms)
      tmo_hit = ((cur.now_ms - last_sync_ms) >= 47'(sync_timeout_ms));
    else
      tmo_hit = (sync_timeout_ms == '0);
    ann_hit = 1'b0;
    if (cur.now_ms >= last_announce_ms)
      ann_hit = ((cur.now_ms - last_announce_ms) >= 47'(announce_period_ms));
    else
      ann_hit = (announce_period_ms == '0);
  end

  assign q_pop = (state == ST_IDLE) && q_valid;

  task automatic put(input send_code_t k, input logic [47:0] p, input logic [7:0] lv,
                     input logic signed [63:0] ts, input logic last);
    out_valid <= 1'b1;
    out_item.send_kind <= k;
    out_item.dest_addr <= p[47:16];
    out_item.dest_port <= p[15:0];
    out_item.out_level <= lv;
    out_item.out_timestamp <= sat48(ts);
    out_item.last_of_run <= last;
  endtask

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      peer_fill <= '0;
      my_level <= LevelUnsynced;
      synced_peer <= '0;
      candidate_peer <= '0;
      synchronizing <= 1'b0;
      current_offset <= '0;
      pending_offset <= '0;
      last_sync_ms <= '0;
      last_announce_ms <= '0;
      sync_timeout_ms <= SyncTimeoutReset;
      announce_period_ms <= AnnouncePeriodReset;
      scan_i <= '0;
      emitted <= '0;
      found <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_SYNC_TIMEOUT:    sync_timeout_ms <= cfg_data;
          CFG_ANNOUNCE_PERIOD: announce_period_ms <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (out_ready) out_valid <= 1'b0;
          if (q_valid) begin
            cur <= q_item;
            state <= ST_TMO;
          end
        end
        ST_TMO: begin
          if (out_ready) out_valid <= 1'b0;
          if (my_level != LevelUnsynced && synced_peer[47:16] != '0 && tmo_hit) begin
            my_level <= LevelUnsynced;
            synced_peer <= '0;
            current_offset <= '0;
          end
          scan_i <= '0;
          found <= 1'b0;
          emitted <= '0;
          state <= ST_DISP;
        end
        ST_DISP: begin
          if (out_ready) out_valid <= 1'b0;
          if (cur.req_type == REQ_TICK) begin
            if ((my_level < LevelNoAnnounce) && ann_hit) begin
              last_announce_ms <= cur.now_ms;
              state <= (peer_fill == '0) ? ST_IDLE : ST_EMIT;
            end else state <= ST_IDLE;
          end else if (cur.req_type == REQ_SYNC_BEGIN || cur.req_type == REQ_DELAY_REQ)
            state <= ST_SCAN;
          else state <= ST_ACT;
        end
        ST_SCAN: begin
          // one table entry per cycle
          if (out_ready) out_valid <= 1'b0;
          if (scan_i >= peer_fill) state <= ST_ACT;
          else begin
            if (peer_table[scan_i[IdxW-1:0]] == sender) found <= 1'b1;
            scan_i <= scan_i + CntW'(1);
          end
        end
        ST_ACT: begin
          // arms that send nothing drop out_valid themselves
          if (!out_valid || out_ready) begin
            state <= ST_IDLE;
            case (cur.req_type)
              REQ_HELLO: begin
                put(SEND_HELLO_REPLY, sender, 8'd0, 64'sd0, 1'b1);
                if (slot_free) begin
                  peer_table[peer_fill[IdxW-1:0]] <= sender;
                  peer_fill <= peer_fill + CntW'(1);
                end
              end
              REQ_CONNECT: begin
                if (slot_free) begin
                  peer_table[peer_fill[IdxW-1:0]] <= sender;
                  peer_fill <= peer_fill + CntW'(1);
                  put(SEND_ACK_CONNECT, sender, 8'd0, 64'sd0, 1'b1);
                end else put(SEND_ERROR, sender, 8'd0, 64'sd0, 1'b1);
              end
              REQ_SYNC_BEGIN: begin
                if (found && cur.msg_level < LevelNoAnnounce) begin
                  logic do_sync;
                  do_sync = synchronizing;
                  if (synced_peer == sender) begin
                    last_sync_ms <= cur.now_ms;
                    if (cur.msg_level >= my_level) begin
                      my_level <= LevelUnsynced;
                      synced_peer <= '0;
                      synchronizing <= 1'b0;
                      do_sync = 1'b0;
                    end else begin
                      candidate_peer <= sender;
                      synchronizing <= 1'b1;
                      do_sync = 1'b1;
                    end
                  end else if ({1'b0, cur.msg_level} < ({1'b0, my_level} - 9'd1)
                               && my_level != 8'd0) begin
                    candidate_peer <= sender;
                    synchronizing <= 1'b1;
                    last_sync_ms <= cur.now_ms;
                    do_sync = 1'b1;
                  end
                  if (do_sync) begin
                    pending_offset <= sat50(($signed({17'd0, cur.now_ms}) <<< 1)
                                            - 64'(cur.msg_timestamp));
                    put(SEND_DELAY_REQ, sender, 8'd0, 64'sd0, 1'b1);
                  end else out_valid <= 1'b0;
                end else put(SEND_ERROR, sender, 8'd0, 64'sd0, 1'b1);
              end
              REQ_DELAY_REQ: begin
                if (my_level != LevelUnsynced && found)
                  put(SEND_DELAY_RESP, sender, my_level, $signed({17'd0, cur.now_ms}), 1'b1);
                else put(SEND_ERROR, sender, 8'd0, 64'sd0, 1'b1);
              end
              REQ_DELAY_RESP: begin
                if (synchronizing && candidate_peer == sender) begin
                  logic signed [OffW-1:0] po;
                  po = sat50(64'(pending_offset) - 64'(cur.msg_timestamp));
                  pending_offset <= po;
                  current_offset <= po / 2;
                  my_level <= cur.msg_level + 8'd1;
                  synced_peer <= sender;
                  synchronizing <= 1'b0;
                  out_valid <= 1'b0;
                end else put(SEND_ERROR, sender, 8'd0, 64'sd0, 1'b1);
              end
              REQ_LEADER: begin
                if (cur.msg_level == 8'd0) begin
                  my_level <= 8'd0;
                  out_valid <= 1'b0;
                end else if (cur.msg_level == LevelUnsynced && my_level == 8'd0) begin
                  my_level <= LevelUnsynced;
                  out_valid <= 1'b0;
                end else put(SEND_ERROR, sender, 8'd0, 64'sd0, 1'b1);
              end
              REQ_GET_TIME: begin
                put(SEND_TIME, sender, my_level,
                    (my_level != LevelUnsynced) ? synced_time
                                                : $signed({17'd0, cur.now_ms}), 1'b1);
              end
              default: put(SEND_ERROR, sender, 8'd0, 64'sd0, 1'b1);
            endcase
          end
        end
        ST_EMIT: begin
          // announcement: one sync message per peer, at most MaxResults
          if (!out_valid || out_ready) begin
            logic last;
            last = ((scan_i + CntW'(1)) >= peer_fill) || (emitted == 5'(MaxResults - 1));
            put(SEND_SYNC_BEGIN, peer_table[scan_i[IdxW-1:0]], my_level, synced_time, last);
            scan_i <= scan_i + CntW'(1);
            emitted <= emitted + 5'd1;
            if (last) state <= ST_IDLE;
          end
        end
        default: begin
          if (out_ready) out_valid <= 1'b0;
          state <= ST_IDLE;
        end
      endcase
    end
  end
endmodule

// ===== hdl/clock_sync_peer_engine.sv =====
// Clock sync peer engine top: front queue and back-end sequencer; needs cspe_pkg.
// Path: an accepted transaction is queued in the front end, then taken by the sequencer
// through IDLE, TMO and DISP, a table search (SCAN) for received sync announcements and
// delay requests, and ACT, which loads the output register; an announcing tick uses EMIT,
// one message per announced peer. One transaction at a time; output stalls hold it up.
// Reset (rst, synchronous): level 255, empty table, registers to 21000 / 6000.
module clock_sync_peer_engine
  import cspe_pkg::*;
#(
  parameter int unsigned PEER_SLOTS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_idx,
  input  logic [CfgW-1:0] cfg_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  req_t            in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output send_t           out_item
);
  // front queue decouples message intake from the sequencer
  logic q_valid, q_pop;
  req_t q_item;

  cspe_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_item,
    .q_valid, .q_pop, .q_item
  );

  // back end owns all protocol state and the output register
  cspe_back #(.PEER_SLOTS(PEER_SLOTS)) u_back (
    .clk, .rst, .cfg_we, .cfg_idx, .cfg_data,
    .q_valid, .q_pop, .q_item,
    .out_valid, .out_ready, .out_item
  );
endmodule

// ===== hdl/cspe_checker.sv =====
// Port-level checker for the clock sync peer engine, bound to the top level.
// Depends on cspe_pkg and clock_sync_peer_engine_assert.svh.
`include "clock_sync_peer_engine_assert.svh"
module cspe_checker
  import cspe_pkg::*;
(
  input logic  clk,
  input logic  rst,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input send_t out_item
);
  `CSPE_ASSERT_IMP(a_kind_nonzero, clk, rst, out_valid, out_item.send_kind != SEND_NONE, "none kind")
  `CSPE_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_item), "output dropped")
  `CSPE_ASSERT_IMP(a_err_zero, clk, rst, out_valid && out_item.send_kind == SEND_ERROR, out_item.out_level == 8'd0 && out_item.out_timestamp == '0, "error payload")
  `CSPE_ASSERT_NXT(a_rst_idle, clk, 1'b0, rst, !out_valid, "output after reset")
  `CSPE_ASSERT_NXT(a_in_hold, clk, rst, in_valid && !in_ready, in_valid, "input dropped")
endmodule

bind clock_sync_peer_engine cspe_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .out_item
);

// ===== dv/clock_sync_peer_engine_tb.sv =====
`timescale 1ns / 1ps
// Testbench for clock_sync_peer_engine: drives messages and ticks, predicts the outgoing
// messages in a scoreboard class and checks each result in order. Depends on cspe_pkg.
module clock_sync_peer_engine_tb;
  import cspe_pkg::*;

  localparam int unsigned Slots = 16;
  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned SettleCycles = 100;

  // Scoreboard: a copy of the engine state and the queue of messages it must send.
  class send_scoreboard;
    logic [47:0] peers[Slots];
    int unsigned npeers;
    logic [7:0] level;
    logic [47:0] synced;
    logic [47:0] candidate;
    bit syncing;
    logic signed [49:0] cur_off;
    logic signed [49:0] pend_off;
    logic [46:0] last_sync;
    logic [46:0] last_announce;
    logic [19:0] timeout_ms;
    logic [19:0] period_ms;
    send_t pending_sends[$];
    int mismatches;
    bit failed;

    function void clear();
      npeers = 0;
      level = LevelUnsynced;
      synced = '0;
      candidate = '0;
      syncing = 0;
      cur_off = '0;
      pend_off = '0;
      last_sync = '0;
      last_announce = '0;
      timeout_ms = SyncTimeoutReset;
      period_ms = AnnouncePeriodReset;
      pending_sends.delete();
      mismatches = 0;
      failed = 0;
    endfunction

    function void write_reg(logic idx, logic [19:0] val);
      if (idx == CFG_SYNC_TIMEOUT) timeout_ms = val;
      else period_ms = val;
    endfunction

    function logic signed [47:0] clip48(longint v);
      if (v > 64'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
      if (v < -64'sh8000_0000_0000) return 48'sh8000_0000_0000;
      return v[47:0];
    endfunction

    function logic signed [49:0] clip50(longint v);
      if (v > 64'sh1_FFFF_FFFF_FFFF) return 50'sh1_FFFF_FFFF_FFFF;
      if (v < -64'sh2_0000_0000_0000) return 50'sh2_0000_0000_0000;
      return v[49:0];
    endfunction

    function longint since(logic [46:0] now, logic [46:0] past);
      return (now >= past) ? longint'(now) - longint'(past) : 0;
    endfunction

    function void push(send_code_t kind, logic [47:0] peer, logic [7:0] lvl, longint ts,
                       ref send_t run[$]);
      send_t s;
      if (run.size() >= MaxResults) return;
      s.send_kind = kind;
      s.dest_addr = peer[47:16];
      s.dest_port = peer[15:0];
      s.out_level = lvl;
      s.out_timestamp = clip48(ts);
      s.last_of_run = 1'b0;
      run.push_back(s);
    endfunction

    function bit known(logic [47:0] p);
      for (int i = 0; i < npeers; i++) if (peers[i] == p) return 1;
      return 0;
    endfunction

    // Notes an accepted request and queues the messages it causes.
    function void note_request(req_t r);
      send_t run[$];
      logic [47:0] who;
      longint now;
      longint ts;
      who = {r.sender_addr, r.src_port};
      now = longint'(r.now_ms);
      ts = longint'(r.msg_timestamp);
      // lost sync after the timeout
      if (level < 8'd255 && synced[47:16] != 0 && since(r.now_ms, last_sync) >= timeout_ms)
        begin
        level = LevelUnsynced;
        synced = '0;
        cur_off = '0;
      end
      case (r.req_type)
        REQ_TICK: begin
          if (level < LevelNoAnnounce && since(r.now_ms, last_announce) >= period_ms) begin
            for (int i = 0; i < npeers; i++)
              push(SEND_SYNC_BEGIN, peers[i], level, now - longint'(cur_off), run);
            last_announce = r.now_ms;
          end
        end
        REQ_HELLO: begin
          push(SEND_HELLO_REPLY, who, 0, 0, run);
          if (npeers < Slots) peers[npeers++] = who;
        end
        REQ_CONNECT: begin
          if (npeers < Slots) begin
            peers[npeers++] = who;
            push(SEND_ACK_CONNECT, who, 0, 0, run);
          end else push(SEND_ERROR, who, 0, 0, run);
        end
        REQ_SYNC_BEGIN: begin
          if (known(who) && r.msg_level < LevelNoAnnounce) begin
            if (synced == who) begin
              last_sync = r.now_ms;
              if (r.msg_level >= level) begin
                level = LevelUnsynced;
                synced = '0;
                syncing = 0;
              end else begin
                candidate = who;
                syncing = 1;
              end
            end else if (int'(r.msg_level) < int'(level) - 1) begin
              candidate = who;
              syncing = 1;
              last_sync = r.now_ms;
            end
            if (syncing) begin
              pend_off = clip50(2 * now - ts);
              push(SEND_DELAY_REQ, who, 0, 0, run);
            end
          end else push(SEND_ERROR, who, 0, 0, run);
        end
        REQ_DELAY_REQ: begin
          if (level != LevelUnsynced && known(who)) push(SEND_DELAY_RESP, who, level, now, run);
          else push(SEND_ERROR, who, 0, 0, run);
        end
        REQ_DELAY_RESP: begin
          if (syncing && candidate == who) begin
            pend_off = clip50(longint'(pend_off) - ts);
            cur_off = pend_off / 2;
            level = r.msg_level + 8'd1;
            synced = who;
            syncing = 0;
          end else push(SEND_ERROR, who, 0, 0, run);
        end
        REQ_LEADER: begin
          if (r.msg_level == 0) level = 0;
          else if (r.msg_level == 8'd255 && level == 0) level = LevelUnsynced;
          else push(SEND_ERROR, who, 0, 0, run);
        end
        REQ_GET_TIME:
          push(SEND_TIME, who, level, (level < 8'd255) ? now - longint'(cur_off) : now, run);
        default: push(SEND_ERROR, who, 0, 0, run);
      endcase
      if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
      foreach (run[i]) pending_sends.push_back(run[i]);
    endfunction

    // Checks one sent message against the oldest expectation.
    function void check_send(send_t got);
      send_t want;
      if (pending_sends.size() == 0) begin
        failed = 1;
        if (mismatches++ < 10) $display("unexpected send %p", got);
        return;
      end
      want = pending_sends.pop_front();
      if (got !== want) begin
        failed = 1;
        if (mismatches++ < 10) $display("send mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_idx;
  logic [CfgW-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  req_t in_item;
  logic out_valid;
  logic out_ready;
  send_t out_item;

  send_scoreboard sb;
  int idle_pct;      // sender idle chance
  int stall_pct;     // receiver stall chance
  bit long_hold;     // receiver held off by the pressure process
  int quiet_cycles;
  logic [46:0] clock_ms;
  logic [47:0] known_peers[$];

  clock_sync_peer_engine #(.PEER_SLOTS(Slots)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Receiver: random stalls, plus a long hold when asked; checks every accepted transaction.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) sb.check_send(out_item);
      out_ready <= !long_hold && ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: cycles with no transaction on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
        $display("clock_sync_peer_engine_tb failed");
        $finish;
      end
    end
  end

  // Offer one request and hold it until accepted; valid stays up for a back-to-back
  // request and is dropped by whoever lets time pass next.
  task automatic send_req(req_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_item <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_request(r);
  endtask

  task automatic send_msg(req_code_t kind, logic [47:0] peer, logic [7:0] lvl,
                          logic signed [47:0] ts, logic [46:0] now);
    req_t r;
    r.req_type = kind;
    r.sender_addr = peer[47:16];
    r.src_port = peer[15:0];
    r.msg_level = lvl;
    r.msg_timestamp = ts;
    r.now_ms = now;
    send_req(r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_sends.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [19:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  function automatic logic [47:0] rand_peer();
    logic [47:0] p;
    p = {$urandom(), 16'($urandom())};
    if (p[47:16] == 0) p[16] = 1'b1;
    return p;
  endfunction

  function automatic logic [47:0] pick_peer();
    if (known_peers.size() == 0 || $urandom_range(9) == 0) return rand_peer();
    return known_peers[$urandom_range(known_peers.size() - 1)];
  endfunction

  // A full sync exchange, mostly with a known peer, with sane timestamps.
  task automatic sync_exchange();
    logic [47:0] p;
    logic [7:0] lvl;
    p = pick_peer();
    lvl = ($urandom_range(3) == 0) ? 8'($urandom()) : 8'($urandom_range(6));
    clock_ms = clock_ms + $urandom_range(2000);
    send_msg(REQ_SYNC_BEGIN, p, lvl, 48'(clock_ms) - $urandom_range(50), clock_ms);
    clock_ms = clock_ms + $urandom_range(20);
    send_msg(REQ_DELAY_RESP, p, lvl, 48'(clock_ms) + $urandom_range(50), clock_ms);
  endtask

  task automatic random_item();
    req_t r;
    int pick;
    pick = $urandom_range(99);
    clock_ms = clock_ms + $urandom_range(3000);
    r.req_type = req_code_t'($urandom_range(15));
    if (pick < 25) r.req_type = REQ_TICK;
    else if (pick < 35) r.req_type = REQ_HELLO;
    {r.sender_addr, r.src_port} = pick_peer();
    r.msg_level = ($urandom_range(1) == 0) ? 8'($urandom_range(4)) : 8'($urandom());
    r.msg_timestamp = ($urandom_range(3) == 0) ? 48'({$urandom(), $urandom()})
                                               : 48'(clock_ms) - $urandom_range(100);
    // occasional time warp, backwards or far forward
    r.now_ms = ($urandom_range(19) == 0) ? 47'({$urandom(), $urandom()}) : clock_ms;
    if (r.req_type == REQ_HELLO && sb.npeers < Slots)
      known_peers.push_back({r.sender_addr, r.src_port});
    if (r.req_type == REQ_SYNC_BEGIN && $urandom_range(1) == 0) begin
      sync_exchange();
    end else if (r.req_type == REQ_LEADER && $urandom_range(1) == 0) begin
      send_msg(REQ_LEADER, pick_peer(), 8'(($urandom_range(1) == 0) ? 0 : 255), 0, clock_ms);
    end else begin
      send_req(r);
    end
  endtask

  task automatic run_phase(int n, int idle, int stall);
    idle_pct = idle;
    stall_pct = stall;
    repeat (n) random_item();
    drain();
  endtask

  initial begin
    logic [47:0] p;
    sb = new();
    sb.clear();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = CFG_SYNC_TIMEOUT;
    cfg_data = '0;
    in_valid = 1'b0;
    in_item = '0;
    idle_pct = 0;
    stall_pct = 0;
    long_hold = 0;
    clock_ms = 47'd1000;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: fill the table past full, every request kind, extreme fields.
    send_msg(REQ_TICK, '0, 0, 0, 0);
    send_msg(REQ_ACK_CONNECT, rand_peer(), 0, 0, 10);
    send_msg(REQ_DELAY_REQ, rand_peer(), 0, 0, 10);       // unsynced, error
    send_msg(REQ_GET_TIME, 48'hFFFF_FFFF_FFFF, 8'hFF, 48'sh7FFF_FFFF_FFFF, 47'h7FFF_FFFF_FFFF);
    for (int i = 0; i < 18; i++) begin
      p = rand_peer();
      if (i < Slots) known_peers.push_back(p);
      if (i % 2) send_msg(REQ_HELLO, p, 0, 0, 20);
      else send_msg(REQ_CONNECT, p, 0, 0, 20);           // last connect hits a full table
    end
    send_msg(REQ_LEADER, known_peers[0], 0, 0, 30);       // become leader
    send_msg(REQ_TICK, '0, 0, 0, 47'h7FFF_FFFF_FFFF);     // announce to every peer
    send_msg(REQ_TICK, '0, 0, 0, 5);                      // time going backwards
    send_msg(REQ_DELAY_REQ, known_peers[1], 0, 0, 40);
    send_msg(REQ_LEADER, known_peers[0], 8'd255, 0, 50);
    send_msg(REQ_LEADER, known_peers[0], 8'd7, 0, 50);    // bad leader request
    send_msg(REQ_SYNC_BEGIN, known_peers[2], 8'd0, 48'sh8000_0000_0000, 47'h7FFF_FFFF_FFFF);
    send_msg(REQ_DELAY_RESP, known_peers[2], 8'd255, 48'sh7FFF_FFFF_FFFF, 47'h7FFF_FFFF_FFFF);
    send_msg(REQ_GET_TIME, known_peers[3], 0, 0, 47'd100);
    send_msg(req_code_t'(4'd15), known_peers[3], 0, 0, 100);
    drain();

    write_reg(CFG_SYNC_TIMEOUT, 20'd1);
    write_reg(CFG_ANNOUNCE_PERIOD, 20'd1);
    run_phase(25, 0, 0);
    write_reg(CFG_SYNC_TIMEOUT, 20'hFFFFF);
    write_reg(CFG_ANNOUNCE_PERIOD, 20'hFFFFF);
    run_phase(25, 61, 0);
    write_reg(CFG_SYNC_TIMEOUT, 20'd21000);
    write_reg(CFG_ANNOUNCE_PERIOD, 20'd2500);
    run_phase(25, 0, 61);

    // Pressure: hold the receiver off while requests keep coming.
    fork
      begin
        long_hold = 1;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end
      begin
        idle_pct = 0;
        repeat (20) random_item();
        in_valid <= 1'b0;
      end
    join
    drain();
    write_reg(CFG_SYNC_TIMEOUT, 20'd3000);
    write_reg(CFG_ANNOUNCE_PERIOD, 20'd600000);
    run_phase(25, 9, 9);

    if (!sb.failed && sb.pending_sends.size() == 0) begin
      $display("clock_sync_peer_engine_tb passed");
    end else begin
      $display("clock_sync_peer_engine_tb failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/cspe_pkg.sv
hdl/cspe_front.sv
hdl/cspe_back.sv
hdl/clock_sync_peer_engine.sv
hdl/cspe_checker.sv
dv/clock_sync_peer_engine_tb.sv
